[hdl/pmtepf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmtepf_pkg
// Shared types and constants of the program map section PID finder.
// ----------------------------------------------------------------------------
package pmtepf_pkg;

  localparam int unsigned MAX_SECTION_BYTES = 4096;
  localparam int unsigned POS_W             = 13;
  localparam int unsigned NEP_W             = 14;
  localparam int unsigned PID_W             = 13;
  localparam int unsigned LEN_W             = 12;
  localparam int unsigned TYPE_W            = 8;
  localparam int unsigned ADDR_W            = 1;
  localparam int unsigned OUT_TDATA_W       = 32;

  localparam logic [ADDR_W-1:0] REG_VIDEO_TYPE = 1'd0;
  localparam logic [ADDR_W-1:0] REG_AUDIO_TYPE = 1'd1;

  localparam logic [TYPE_W-1:0] VIDEO_TYPE_RST = 8'd27;
  localparam logic [TYPE_W-1:0] AUDIO_TYPE_RST = 8'd17;

  localparam logic [POS_W-1:0] POS_INFO_HI    = 13'd10;
  localparam logic [POS_W-1:0] POS_INFO_LO    = 13'd11;
  localparam logic [POS_W-1:0] POS_FIRST_LOOP = 13'd12;
  localparam logic [POS_W-1:0] POS_SHORT_MAX  = 13'd14;
  localparam logic [POS_W-1:0] POS_LIMIT      = POS_W'(MAX_SECTION_BYTES);
  localparam logic [NEP_W-1:0] ENTRY_HDR_LEN  = 14'd5;

  // offsets within an entry header
  localparam logic [2:0] ENT_TYPE    = 3'd0;
  localparam logic [2:0] ENT_PID_HI  = 3'd1;
  localparam logic [2:0] ENT_PID_LO  = 3'd2;
  localparam logic [2:0] ENT_INFO_HI = 3'd3;
  localparam logic [2:0] ENT_INFO_LO = 3'd4;

  typedef struct packed {
    logic [PID_W-1:0] vid_pid;
    logic [PID_W-1:0] aud_pid;
    logic             short_section;
  } pmtepf_result_t;

  typedef struct packed {
    logic [TYPE_W-1:0] video_type;
    logic [TYPE_W-1:0] audio_type;
  } pmtepf_cfg_t;

endpackage
`default_nettype wire

[hdl/pmtepf_walk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmtepf_walk
// Section walk state: byte count, loop offsets, entry decode and held PIDs.
// ----------------------------------------------------------------------------
module pmtepf_walk (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire pmtepf_pkg::pmtepf_cfg_t     cfg,
  input  wire                              step_valid,
  input  wire [7:0]                        step_byte,
  input  wire                              step_last,
  output pmtepf_pkg::pmtepf_result_t       result
);
  import pmtepf_pkg::*;

  logic [POS_W-1:0]  byte_pos_r,    byte_pos_nxt;
  logic [LEN_W-1:0]  prog_info_r,   prog_info_nxt;
  logic [NEP_W-1:0]  next_entry_r,  next_entry_nxt;
  logic [2:0]        ent_idx_r,     ent_idx_nxt;
  logic [TYPE_W-1:0] ent_type_r,    ent_type_nxt;
  logic [PID_W-1:0]  ent_pid_r,     ent_pid_nxt;
  logic [LEN_W-1:0]  ent_info_r,    ent_info_nxt;
  logic              stopped_r,     stopped_nxt;
  logic [PID_W-1:0]  vid_pid_r,     vid_pid_nxt;
  logic [PID_W-1:0]  aud_pid_r,     aud_pid_nxt;

  logic              take;
  logic [NEP_W-1:0]  pos_ext;
  logic [NEP_W-1:0]  diff;
  logic              in_entry;
  logic [LEN_W-1:0]  info_full;
  logic [POS_W-1:0]  pos_count;

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    prog_info_nxt  = prog_info_r;
    next_entry_nxt = next_entry_r;
    ent_idx_nxt    = ent_idx_r;
    ent_type_nxt   = ent_type_r;
    ent_pid_nxt    = ent_pid_r;
    ent_info_nxt   = ent_info_r;
    stopped_nxt    = stopped_r;
    vid_pid_nxt    = vid_pid_r;
    aud_pid_nxt    = aud_pid_r;

    take      = step_valid && (byte_pos_r < POS_LIMIT);
    pos_ext   = {1'b0, byte_pos_r};
    diff      = pos_ext - next_entry_r;
    in_entry  = (byte_pos_r >= POS_FIRST_LOOP) && !stopped_r &&
                (pos_ext >= next_entry_r) && (diff < ENTRY_HDR_LEN);
    info_full = {ent_info_r[LEN_W-1:8], step_byte};
    pos_count = take ? byte_pos_r + 1'b1 : byte_pos_r;

    if (take) begin
      byte_pos_nxt = pos_count;
      if (byte_pos_r == POS_INFO_HI) begin
        prog_info_nxt = {step_byte[3:0], 8'h00};
      end else if (byte_pos_r == POS_INFO_LO) begin
        prog_info_nxt  = {prog_info_r[LEN_W-1:8], step_byte};
        next_entry_nxt = NEP_W'(POS_FIRST_LOOP) +
                         NEP_W'({prog_info_r[LEN_W-1:8], step_byte});
      end else if (in_entry) begin
        ent_idx_nxt = diff[2:0];
        case (diff[2:0])
          ENT_TYPE:    ent_type_nxt = step_byte;
          ENT_PID_HI:  ent_pid_nxt  = {step_byte[4:0], 8'h00};
          ENT_PID_LO:  ent_pid_nxt  = {ent_pid_r[PID_W-1:8], step_byte};
          ENT_INFO_HI: ent_info_nxt = {step_byte[3:0], 8'h00};
          ENT_INFO_LO: begin
            ent_info_nxt = info_full;
            if (ent_type_r == cfg.video_type) begin
              vid_pid_nxt = ent_pid_r;
            end else if (aud_pid_r == '0 && ent_type_r == cfg.audio_type) begin
              aud_pid_nxt = ent_pid_r;
            end
            next_entry_nxt = next_entry_r + ENTRY_HDR_LEN + NEP_W'(info_full);
            stopped_nxt    = (vid_pid_nxt != '0) && (aud_pid_nxt != '0);
          end
          default: ;
        endcase
      end
    end

    result.vid_pid       = vid_pid_nxt;
    result.aud_pid       = aud_pid_nxt;
    result.short_section = (pos_count <= POS_SHORT_MAX);

    // end of section: start the next one clean
    if (step_valid && step_last) begin
      byte_pos_nxt   = '0;
      prog_info_nxt  = '0;
      next_entry_nxt = '0;
      ent_idx_nxt    = '0;
      ent_type_nxt   = '0;
      ent_pid_nxt    = '0;
      ent_info_nxt   = '0;
      stopped_nxt    = 1'b0;
      vid_pid_nxt    = '0;
      aud_pid_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      prog_info_r  <= '0;
      next_entry_r <= '0;
      ent_idx_r    <= '0;
      ent_type_r   <= '0;
      ent_pid_r    <= '0;
      ent_info_r   <= '0;
      stopped_r    <= 1'b0;
      vid_pid_r    <= '0;
      aud_pid_r    <= '0;
    end else begin
      byte_pos_r   <= byte_pos_nxt;
      prog_info_r  <= prog_info_nxt;
      next_entry_r <= next_entry_nxt;
      ent_idx_r    <= ent_idx_nxt;
      ent_type_r   <= ent_type_nxt;
      ent_pid_r    <= ent_pid_nxt;
      ent_info_r   <= ent_info_nxt;
      stopped_r    <= stopped_nxt;
      vid_pid_r    <= vid_pid_nxt;
      aud_pid_r    <= aud_pid_nxt;
    end
  end

  a_stop_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (vid_pid_r != '0 && aud_pid_r != '0))
    else $error("search stopped without both pids");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= POS_LIMIT)
    else $error("byte count beyond section limit");

  a_entry_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ent_idx_r <= ENT_INFO_LO)
    else $error("entry byte index out of range");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && step_last) |=> (byte_pos_r == '0 && !stopped_r))
    else $error("section state not cleared after last byte");

endmodule
`default_nettype wire

[hdl/pmt_elementary_pid_finder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmt_elementary_pid_finder_core
// Walks a program map section byte by byte and reports video and audio PIDs.
// ----------------------------------------------------------------------------
// Takes one section byte per cycle while not stalled. Each byte lands in an input
// register and is folded into the section state when the walk stage takes it; the
// item with tlast loads the result register on that same edge, which raises
// out_tvalid. The only stall comes from a pending result
// that the sink has not taken when the next last byte reaches the walk stage.
module pmt_elementary_pid_finder_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [pmtepf_pkg::ADDR_W-1:0]          cfg_addr,
  input  wire [pmtepf_pkg::TYPE_W-1:0]          cfg_wdata,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire [7:0]                             in_tdata,   // section_byte
  input  wire                                   in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // vid_pid[12:0], aud_pid[25:13], short_section[26], zero above
  output logic [pmtepf_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import pmtepf_pkg::*;

  pmtepf_cfg_t    cfg_r;
  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;
  logic           s1_go;
  logic           out_valid_r;
  pmtepf_result_t out_data_r;
  pmtepf_result_t walk_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.video_type <= VIDEO_TYPE_RST;
      cfg_r.audio_type <= AUDIO_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VIDEO_TYPE: cfg_r.video_type <= cfg_wdata;
        REG_AUDIO_TYPE: cfg_r.audio_type <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  pmtepf_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step_valid (s1_go),
    .step_byte  (s1_byte_r),
    .step_last  (s1_last_r),
    .result     (walk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_data_r <= walk_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*PID_W - 1){1'b0}}, out_data_r.short_section,
                       out_data_r.aud_pid, out_data_r.vid_pid};

endmodule
`default_nettype wire

[verif/pmt_elementary_pid_finder_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_elementary_pid_finder_core_test
// Streams program map sections into the PID finder and checks every report
// against a byte-level model of the section walk. Sections are mostly
// well-formed with random entries; some are cut short or pure noise.
// Stream type registers change between phases, and the phases vary source
// gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module pmt_elementary_pid_finder_core_test;
  import pmtepf_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  class pid_scoreboard;
    logic [TYPE_W-1:0] video_type;
    logic [TYPE_W-1:0] audio_type;
    int unsigned       pos;
    int unsigned       entry_start;
    logic [LEN_W-1:0]  prog_info_len;
    logic [TYPE_W-1:0] ent_type;
    logic [PID_W-1:0]  ent_pid;
    logic [LEN_W-1:0]  ent_len;
    bit                stopped;
    logic [PID_W-1:0]  video_held;
    logic [PID_W-1:0]  audio_held;
    pmtepf_result_t    expected_q[$];
    int                errors;

    function new();
      video_type = VIDEO_TYPE_RST;
      audio_type = AUDIO_TYPE_RST;
      errors = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      pos = 0;
      entry_start = 0;
      prog_info_len = '0;
      ent_type = '0;
      ent_pid = '0;
      ent_len = '0;
      stopped = 1'b0;
      video_held = '0;
      audio_held = '0;
    endfunction

    function void set_reg(logic [ADDR_W-1:0] idx, logic [TYPE_W-1:0] val);
      if (idx == REG_VIDEO_TYPE) video_type = val;
      else if (idx == REG_AUDIO_TYPE) audio_type = val;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned    d;
      pmtepf_result_t r;
      if (pos < MAX_SECTION_BYTES) begin
        if (pos == POS_INFO_HI) begin
          prog_info_len = {b[3:0], 8'h00};
        end else if (pos == POS_INFO_LO) begin
          prog_info_len = {prog_info_len[11:8], b};
          entry_start = POS_FIRST_LOOP + prog_info_len;
        end else if (pos >= POS_FIRST_LOOP && !stopped && pos >= entry_start &&
                     pos - entry_start < ENTRY_HDR_LEN) begin
          d = pos - entry_start;
          case (d)
            ENT_TYPE:    ent_type = b;
            ENT_PID_HI:  ent_pid = {b[4:0], 8'h00};
            ENT_PID_LO:  ent_pid = {ent_pid[12:8], b};
            ENT_INFO_HI: ent_len = {b[3:0], 8'h00};
            default: begin
              ent_len = {ent_len[11:8], b};
              if (ent_type == video_type) video_held = ent_pid;
              else if (audio_held == 0 && ent_type == audio_type) audio_held = ent_pid;
              entry_start = entry_start + ENTRY_HDR_LEN + ent_len;
              if (video_held != 0 && audio_held != 0) stopped = 1'b1;
            end
          endcase
        end
        pos++;
      end
      if (last) begin
        r.vid_pid = video_held;
        r.aud_pid = audio_held;
        r.short_section = (pos <= POS_SHORT_MAX);
        expected_q.push_back(r);
        clear_walk();
      end
    endfunction

    function void check_pids(logic [OUT_TDATA_W-1:0] td);
      pmtepf_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no section pending: tdata %h", td);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (td[12:0] !== exp_r.vid_pid) begin
        $error("vid_pid: expected %0d, actual %0d", exp_r.vid_pid, td[12:0]);
        errors++;
      end
      if (td[25:13] !== exp_r.aud_pid) begin
        $error("aud_pid: expected %0d, actual %0d", exp_r.aud_pid, td[25:13]);
        errors++;
      end
      if (td[26] !== exp_r.short_section) begin
        $error("short_section: expected %0d, actual %0d", exp_r.short_section, td[26]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [ADDR_W-1:0]      cfg_addr = '0;
  logic [TYPE_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pid_scoreboard sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;

  pmt_elementary_pid_finder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // sink side: random stalls, or a counted hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_pids(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("pmt_elementary_pid_finder_core: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [ADDR_W-1:0] idx, logic [TYPE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_section(ref logic [7:0] sec[$]);
    foreach (sec[i]) push_byte(sec[i], i == sec.size() - 1);
  endtask

  function automatic void make_section(ref logic [7:0] sec[$]);
    logic [LEN_W-1:0]  len;
    logic [PID_W-1:0]  pid;
    logic [TYPE_W-1:0] st;
    int unsigned       n_ent;
    int unsigned       cut;
    sec.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(40, 1)) sec.push_back(8'($urandom));
      return;
    end
    repeat (10) sec.push_back(8'($urandom));
    len = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(6));
    sec.push_back({4'($urandom), len[11:8]});
    sec.push_back(len[7:0]);
    if (len > 6) begin
      // long program info: only random filler follows, no entries
      repeat ($urandom_range(20)) sec.push_back(8'($urandom));
      n_ent = 0;
    end else begin
      repeat (len) sec.push_back(8'($urandom));
      n_ent = $urandom_range(6);
    end
    for (int e = 0; e < n_ent; e++) begin
      case ($urandom_range(5))
        0, 1:    st = sb.video_type;
        2, 3:    st = sb.audio_type;
        4:       st = 8'($urandom);
        default: st = $urandom_range(1) ? 8'hff : 8'h00;
      endcase
      pid = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom);
      len = ($urandom_range(19) == 0) ? 12'($urandom) : 12'($urandom_range(5));
      sec.push_back(st);
      sec.push_back({3'($urandom), pid[12:8]});
      sec.push_back(pid[7:0]);
      sec.push_back({4'($urandom), len[11:8]});
      sec.push_back(len[7:0]);
      if (len > 5) begin
        repeat ($urandom_range(10)) sec.push_back(8'($urandom));
        break;
      end
      repeat (len) sec.push_back(8'($urandom));
    end
    repeat (4) sec.push_back(8'($urandom));
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(sec.size(), 1);
      sec = sec[0:cut-1];
    end
  endfunction

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, logic [TYPE_W-1:0] vt,
                           logic [TYPE_W-1:0] at, int unsigned n_bytes,
                           int unsigned hold, bit overlong);
    logic [7:0]  sec[$];
    int unsigned sent;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_VIDEO_TYPE, vt);
    write_reg(REG_AUDIO_TYPE, at);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    hold_left = hold;
    sent = 0;
    if (overlong) begin
      make_section(sec);
      while (sec.size() < MAX_SECTION_BYTES + 8) sec.push_back(8'($urandom));
      send_section(sec);
    end
    while (sent < n_bytes) begin
      make_section(sec);
      send_section(sec);
      sent += sec.size();
    end
  endtask

  initial begin
    logic [7:0] sec[$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single byte section, then one entry with all-ones pid under reset types
    sec = '{8'hff};
    send_section(sec);
    sec.delete();
    repeat (10) sec.push_back(8'h00);
    sec.push_back(8'hf0);
    sec.push_back(8'h00);
    sec.push_back(VIDEO_TYPE_RST);
    sec.push_back(8'hff);
    sec.push_back(8'hff);
    sec.push_back(8'hf0);
    sec.push_back(8'h00);
    send_section(sec);
    sec = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_section(sec);

    run_phase(0, 0, 8'h00, 8'hff, 500, 0, 1'b0);
    run_phase(80, 0, 8'hff, 8'h00, 450, 0, 1'b0);
    run_phase(0, 80, VIDEO_TYPE_RST, AUDIO_TYPE_RST, 450, 0, 1'b0);
    run_phase(15, 15, 8'h02, 8'h02, 300, 0, 1'b0);
    run_phase(0, 0, 8'($urandom), 8'($urandom), 250, 400, 1'b0);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("pmt_elementary_pid_finder_core: match");
    end else begin
      $display("pmt_elementary_pid_finder_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pmtepf_pkg.sv
hdl/pmtepf_walk.sv
hdl/pmt_elementary_pid_finder_core.sv
verif/pmt_elementary_pid_finder_core_test.sv
